FILE: rtl/ffba_pkg.sv
// types and codes shared by the first-fit block allocator
`timescale 1ns / 1ps
package ffba_pkg;

  // request modes
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_RESIZE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_NULL       = 3'd1;
  localparam logic [2:0] ST_HEAP_FULL  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_UNKNOWN    = 3'd4;

  // register indexes on the config port
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  // packed item widths
  localparam int IN_BYTES  = 9;
  localparam int OUT_BYTES = 9;

  // one block table entry
  typedef struct packed {
    logic        is_free;
    logic [31:0] bytes;
    logic [31:0] start;
  } entry_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FIT     = 6'b000010,
    S_FIND    = 6'b000100,
    S_APPEND  = 6'b001000,
    S_RELEASE = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

endpackage

FILE: rtl/first_fit_block_allocator.sv
// first-fit heap allocator: block table, scan sequencer and stream/config ports
//
//   channel   direction  signals                               contents
//   s_axis    in         s_axis_tvalid/tready/tdata            mode, request_size, block_address
//   m_axis    out        m_axis_tvalid/tready/tdata            result_address, status, copy_bytes
//   apb       in/out     psel/penable/pwrite/paddr/pwdata/...  heap_base at 0, heap_limit at 4
//
// an allocate or free scans the entries in use at most once, and a moving resize
// does a find scan and then a fit scan over them; the table scan reads one entry
// per cycle from the block table memory
// reset is synchronous and clears the break, the entry count and both channels
// s_axis_tready is high only while the sequencer is idle; the result sits in an
// output register, so a new item is taken while m_axis_tready is low
`timescale 1ns / 1ps
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] mode, [33:2] request_size, [65:34] block_address, zero fill above
  input  logic [8*ffba_pkg::IN_BYTES-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] result_address, [34:32] status, [66:35] copy_bytes, zero fill above
  output logic [8*ffba_pkg::OUT_BYTES-1:0]    m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ffba_pkg::*;

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BLOCKS);

  // block table memory
  entry_t mem [MAX_BLOCKS];
  entry_t rd_entry;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  // control and state
  state_t        state;
  logic [31:0]   heap_base;
  logic [31:0]   heap_limit;
  logic [31:0]   heap_break;
  logic [CW-1:0] entry_count;
  logic [1:0]    op_mode;
  logic [31:0]   op_size;
  logic [31:0]   op_addr;
  logic          move;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] chk_idx;
  logic          pend;
  logic [CW-1:0] old_idx;
  logic [31:0]   old_start;
  logic [31:0]   old_bytes;
  logic [31:0]   res_addr;
  logic [2:0]    res_status;
  logic [31:0]   res_copy;

  logic          chk_live;
  logic          scan_end;
  logic          fit_hit;
  logic          find_match;
  logic          heap_fail;
  logic          table_full;
  logic          old_last;
  logic [33:0]   need;
  logic          in_acc;
  logic          cfg_wr;

  assign pready        = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign prdata        = (paddr[2] == REG_HEAP_LIMIT) ? heap_limit : heap_base;

  // shared compare unit on the entry just read
  always_comb begin
    chk_live   = pend && (chk_idx < entry_count);
    scan_end   = pend && !(chk_idx < entry_count);
    fit_hit    = (state == S_FIT) && chk_live && rd_entry.is_free &&
                 (rd_entry.bytes >= op_size);
    find_match = (state == S_FIND) && chk_live && ((rd_entry.start + HDR) == op_addr);
    need       = {2'b00, heap_break} + {2'b00, HDR} + {2'b00, op_size};
    heap_fail  = need > {2'b00, heap_limit};
    table_full = (entry_count == FULL_COUNT);
    old_last   = ((old_idx + CW'(1)) == entry_count);
  end

  // table write select
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rd_entry;
    if (fit_hit) begin
      we            = 1'b1;
      waddr         = chk_idx[AW-1:0];
      wdata.is_free = 1'b0;
    end else if ((state == S_APPEND) && !heap_fail && !table_full) begin
      we            = 1'b1;
      waddr         = entry_count[AW-1:0];
      wdata.is_free = 1'b0;
      wdata.bytes   = op_size;
      wdata.start   = heap_base + heap_break;
    end else if ((state == S_RELEASE) && !old_last) begin
      we            = 1'b1;
      waddr         = old_idx[AW-1:0];
      wdata.is_free = 1'b1;
      wdata.bytes   = old_bytes;
      wdata.start   = old_start;
    end
  end

  // table memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_entry <= mem[scan_idx[AW-1:0]];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= 32'h1000_0000;
      heap_limit <= 32'd65536;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HEAP_BASE) begin
        heap_base <= pwdata;
      end else begin
        heap_limit <= pwdata;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      heap_break  <= '0;
      entry_count <= '0;
      pend        <= 1'b0;
      scan_idx    <= '0;
      move        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_mode    <= s_axis_tdata[1:0];
            op_size    <= s_axis_tdata[33:2];
            op_addr    <= s_axis_tdata[65:34];
            res_addr   <= '0;
            res_copy   <= '0;
            res_status <= ST_NULL;
            move       <= 1'b0;
            scan_idx   <= '0;
            pend       <= 1'b0;
            case (s_axis_tdata[1:0])
              MODE_ALLOC: begin
                state <= (s_axis_tdata[33:2] == '0) ? S_DONE : S_FIT;
              end
              MODE_FREE: begin
                state <= (s_axis_tdata[65:34] == '0) ? S_DONE : S_FIND;
              end
              MODE_RESIZE: begin
                if (s_axis_tdata[33:2] == '0) begin
                  state <= S_DONE;
                end else if (s_axis_tdata[65:34] == '0) begin
                  state <= S_FIT;
                end else begin
                  state <= S_FIND;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FIT: begin
          scan_idx <= scan_idx + CW'(1);
          chk_idx  <= scan_idx;
          pend     <= 1'b1;
          if (fit_hit) begin
            res_addr   <= rd_entry.start + HDR;
            res_status <= ST_DONE;
            if (move) begin
              res_copy <= old_bytes;
              state    <= S_RELEASE;
            end else begin
              state <= S_DONE;
            end
          end else if (scan_end) begin
            state <= S_APPEND;
          end
        end
        S_FIND: begin
          scan_idx <= scan_idx + CW'(1);
          chk_idx  <= scan_idx;
          pend     <= 1'b1;
          if (find_match) begin
            old_idx   <= chk_idx;
            old_start <= rd_entry.start;
            old_bytes <= rd_entry.bytes;
            if (rd_entry.is_free) begin
              res_status <= ST_UNKNOWN;
              state      <= S_DONE;
            end else if (op_mode == MODE_FREE) begin
              res_status <= ST_DONE;
              state      <= S_RELEASE;
            end else if (rd_entry.bytes >= op_size) begin
              res_addr   <= op_addr;
              res_status <= ST_DONE;
              state      <= S_DONE;
            end else begin
              move     <= 1'b1;
              scan_idx <= '0;
              pend     <= 1'b0;
              state    <= S_FIT;
            end
          end else if (scan_end) begin
            res_status <= ST_UNKNOWN;
            state      <= S_DONE;
          end
        end
        S_APPEND: begin
          if (heap_fail) begin
            res_status <= ST_HEAP_FULL;
            state      <= S_DONE;
          end else if (table_full) begin
            res_status <= ST_TABLE_FULL;
            state      <= S_DONE;
          end else begin
            res_addr    <= heap_base + heap_break + HDR;
            res_status  <= ST_DONE;
            entry_count <= entry_count + CW'(1);
            heap_break  <= need[31:0];
            if (move) begin
              res_copy <= old_bytes;
              state    <= S_RELEASE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RELEASE: begin
          if (old_last) begin
            heap_break  <= heap_break - HDR - old_bytes;
            entry_count <= old_idx;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {5'b0, res_copy, res_status, res_addr};
    end
  end

endmodule

FILE: tb/sv/first_fit_block_allocator_tb.sv
// testbench for the first-fit block allocator: directed table, random traffic, scoreboard
`timescale 1ns / 1ps
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int NBLK = 64;
  localparam int HDR  = 12;
  localparam int WDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [8*IN_BYTES-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [8*OUT_BYTES-1:0] m_axis_tdata;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  first_fit_block_allocator #(.MAX_BLOCKS(NBLK), .HEADER_BYTES(HDR)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [31:0] copy;
    logic [2:0]  st;
    logic [31:0] addr;
  } grant_t;

  // allocator shadow state
  logic [31:0] sh_base, sh_limit, sh_break;
  logic [31:0] sh_start [NBLK];
  logic [31:0] sh_bytes [NBLK];
  logic        sh_free  [NBLK];
  int          sh_count;

  grant_t grant_q[$];
  int     errors;
  int     idle_pct_s, idle_pct_m;
  bit     hold_m;
  int     wdog;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [2:0] shadow_alloc(input logic [31:0] size, output logic [31:0] ua);
    logic [63:0] total;
    ua = '0;
    if (size == 0) return ST_NULL;
    for (int i = 0; i < sh_count; i++) begin
      if (sh_free[i] && sh_bytes[i] >= size) begin
        sh_free[i] = 1'b0;
        ua = sh_start[i] + HDR;
        return ST_DONE;
      end
    end
    total = 64'(HDR) + 64'(size);
    if (64'(sh_break) + total > 64'(sh_limit)) return ST_HEAP_FULL;
    if (sh_count >= NBLK) return ST_TABLE_FULL;
    sh_start[sh_count] = sh_base + sh_break;
    sh_bytes[sh_count] = size;
    sh_free[sh_count] = 1'b0;
    ua = sh_base + sh_break + HDR;
    sh_count++;
    sh_break = 32'(64'(sh_break) + total);
    return ST_DONE;
  endfunction

  function automatic int shadow_find(input logic [31:0] a);
    for (int i = 0; i < sh_count; i++)
      if (sh_start[i] + HDR == a) return sh_free[i] ? NBLK : i;
    return NBLK;
  endfunction

  function automatic void shadow_release(input int i);
    if (i + 1 == sh_count) begin
      sh_break = sh_break - HDR - sh_bytes[i];
      sh_count = i;
    end else begin
      sh_free[i] = 1'b1;
    end
  endfunction

  function automatic grant_t predict_grant(input logic [1:0] md, input logic [31:0] sz,
                                           input logic [31:0] ba);
    grant_t g;
    int idx;
    g = '0;
    g.st = ST_NULL;
    if (md == MODE_ALLOC) begin
      g.st = shadow_alloc(sz, g.addr);
    end else if (md == MODE_FREE) begin
      if (ba != 0) begin
        idx = shadow_find(ba);
        if (idx >= NBLK) g.st = ST_UNKNOWN;
        else begin
          shadow_release(idx);
          g.st = ST_DONE;
        end
      end
    end else if (md == MODE_RESIZE) begin
      if (ba == 0 || sz == 0) g.st = shadow_alloc(sz, g.addr);
      else begin
        idx = shadow_find(ba);
        if (idx >= NBLK) g.st = ST_UNKNOWN;
        else if (sh_bytes[idx] >= sz) begin
          g.addr = ba;
          g.st = ST_DONE;
        end else begin
          g.st = shadow_alloc(sz, g.addr);
          if (g.st == ST_DONE) begin
            g.copy = sh_bytes[idx];
            shadow_release(idx);
          end
        end
      end
    end
    return g;
  endfunction

  // one apb write, setup then access
  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_HEAP_BASE) sh_base = val;
    else sh_limit = val;
  endtask

  // one item on the input stream, with random idle before it
  task automatic send_req(input logic [1:0] md, input logic [31:0] sz, input logic [31:0] ba,
                          input bit has_exp, input grant_t exp);
    grant_t g;
    while ($urandom_range(99) < idle_pct_s) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, ba, sz, md};
    do @(posedge clk); while (!s_axis_tready);
    g = predict_grant(md, sz, ba);
    if (has_exp && g != exp) begin
      $display("%0t directed row disagrees: table %h predictor %h", $time, exp, g);
      errors++;
    end
    grant_q.push_back(g);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // pick an address: mostly table entries, sometimes null, stale or junk
  function automatic logic [31:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (sh_count > 0 && r < 75) return sh_start[$urandom_range(sh_count - 1)] + HDR;
    if (r < 82) return 32'h0;
    if (r < 90) return sh_base + HDR + $urandom_range(4095);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 200);
    if (r < 80) return $urandom_range(1, 2000);
    if (r < 85) return 32'h0;
    if (r < 92) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(15);
  endfunction

  task automatic random_burst(input int n);
    int r;
    logic [1:0] md;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      md = (r < 45) ? MODE_ALLOC : (r < 75) ? MODE_FREE : (r < 97) ? MODE_RESIZE : MODE_UNUSED;
      send_req(md, pick_size(), pick_addr(), 1'b0, '0);
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    grant_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[66:0];
        if (grant_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, got);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (got.addr != want.addr)
            $display("%0t result_address mismatch: expected %h actual %h",
                     $time, want.addr, got.addr);
          if (got.st != want.st)
            $display("%0t status mismatch: expected %0d actual %0d", $time, want.st, got.st);
          if (got.copy != want.copy)
            $display("%0t copy_bytes mismatch: expected %h actual %h",
                     $time, want.copy, got.copy);
          if (got != want) errors++;
        end
      end
      m_axis_tready <= !hold_m && ($urandom_range(99) >= idle_pct_m);
    end
  end

  // watchdog on cycles with no accepted item and no apb access
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  typedef struct {
    logic [1:0]  md;
    logic [31:0] sz;
    logic [31:0] ba;
    bit          has_exp;
    grant_t      exp;
  } row_t;

  row_t rows[$];
  logic [31:0] u0;

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_m = 1'b0;
    idle_pct_s = 0; idle_pct_m = 0;
    errors = 0;
    sh_base = 32'h1000_0000; sh_limit = 32'd65536; sh_break = 0; sh_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset settings
    u0 = 32'h1000_0000 + HDR;
    rows = '{
      '{MODE_ALLOC, 32'd0, 32'd0, 1, '{32'd0, ST_NULL, 32'd0}},
      '{MODE_FREE, 32'd0, 32'd0, 1, '{32'd0, ST_NULL, 32'd0}},
      '{MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{32'd0, ST_NULL, 32'd0}},
      '{MODE_FREE, 32'd0, 32'hFFFF_FFFF, 1, '{32'd0, ST_UNKNOWN, 32'd0}},
      '{MODE_ALLOC, 32'hFFFF_FFFF, 32'd0, 1, '{32'd0, ST_HEAP_FULL, 32'd0}},
      '{MODE_ALLOC, 32'd100, 32'd0, 1, '{32'd0, ST_DONE, u0}},
      '{MODE_RESIZE, 32'd0, u0, 1, '{32'd0, ST_NULL, 32'd0}},
      '{MODE_RESIZE, 32'd50, u0, 1, '{32'd0, ST_DONE, u0}},
      '{MODE_ALLOC, 32'd40, 32'd0, 0, '0},
      '{MODE_FREE, 32'd0, u0, 0, '0},
      '{MODE_FREE, 32'd0, u0, 1, '{32'd0, ST_UNKNOWN, 32'd0}},
      '{MODE_ALLOC, 32'd80, 32'd0, 1, '{32'd0, ST_DONE, u0}},
      '{MODE_RESIZE, 32'd500, u0, 0, '0},
      '{MODE_RESIZE, 32'd20, 32'd0, 0, '0},
      '{MODE_RESIZE, 32'hFFFF_FFFF, u0 + 152, 0, '0},
      '{MODE_ALLOC, 32'd65536, 32'd0, 0, '0},
      '{MODE_ALLOC, 32'd1, 32'd0, 0, '0}
    };
    foreach (rows[i]) send_req(rows[i].md, rows[i].sz, rows[i].ba, rows[i].has_exp, rows[i].exp);
    drain();

    // table full: many tiny blocks with a roomy limit
    reg_write(REG_HEAP_BASE, 32'hFFFF_FF00);
    reg_write(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    for (int k = 0; k < 66; k++) send_req(MODE_ALLOC, 32'd1, 32'd0, 1'b0, '0);
    drain();

    // no idling
    random_burst(200);
    drain();

    // sender idle
    reg_write(REG_HEAP_BASE, 32'h0);
    reg_write(REG_HEAP_LIMIT, 32'd4000);
    idle_pct_s = 72;
    random_burst(200);
    drain();

    // receiver stall, with a long hold-off so the block backs up
    idle_pct_s = 0; idle_pct_m = 72;
    hold_m = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_m = 1'b0;
      end
      random_burst(220);
    join
    drain();

    // both sides idle, extreme settings, then a random base
    reg_write(REG_HEAP_BASE, 32'hFFFF_FFFF);
    reg_write(REG_HEAP_LIMIT, 32'h0);
    idle_pct_s = 35; idle_pct_m = 35;
    random_burst(40);
    drain();
    reg_write(REG_HEAP_BASE, $urandom);
    reg_write(REG_HEAP_LIMIT, 32'd30000);
    random_burst(360);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
